FILE: sv/dogs_pkg.sv
// Package for the disc occupancy grid stamper.
// Holds grid size defaults, command codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package dogs_pkg;

  localparam int unsigned DefCellsX = 64;
  localparam int unsigned DefCellsY = 64;
  localparam int unsigned DefLayers = 16;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdStamp = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  localparam logic [3:0] RegRobotX    = 4'd0;
  localparam logic [3:0] RegRobotY    = 4'd1;
  localparam logic [3:0] RegCosYaw    = 4'd2;
  localparam logic [3:0] RegSinYaw    = 4'd3;
  localparam logic [3:0] RegCellSizeX = 4'd4;
  localparam logic [3:0] RegCellSizeY = 4'd5;
  localparam logic [3:0] RegOriginX   = 4'd6;
  localparam logic [3:0] RegOriginY   = 4'd7;

endpackage

FILE: sv/disc_occupancy_grid_stamper_unit.sv
// Top level of the disc occupancy grid stamper: sequencer, shared divider and grid memory.
// Depends on dogs_pkg.
`timescale 1ns / 1ps

// Usage:
// Input beats arrive on the s_axis channel, the command in tuser. Every beat gives exactly
// one result beat on m_axis, whose tdata bit 0 is the read cell bit (0 for other commands).
// Configuration registers are written on the cfg channel, which is always ready; write
// them only while the block is idle.
// The grid is a memory of LAYERS*CELLS_Y rows of CELLS_X bits, one row per word.
// A read fetches the row, then selects the cell bit. A clear sweeps every row.
// A stamp first computes the rotated item position and then runs the four bounding-box
// divisions on one shared radix-2 divider; it then reads each row of the box, squares
// and tests each cell of a row that reaches the disc, and writes that row back.
// After reset the block runs the same clearing sweep before it takes its first beat.
// A finished result waits in an output register; the block accepts the next beat
// meanwhile, and stalls only when a second result is ready while the first is not taken.
module disc_occupancy_grid_stamper_unit
  import dogs_pkg::*;
#(
  parameter int unsigned CELLS_X = DefCellsX,
  parameter int unsigned CELLS_Y = DefCellsY,
  parameter int unsigned LAYERS  = DefLayers
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x[31:0], pos_y[63:32], disc_radius[86:64], layer[90:87], cell_x[96:91],
  // cell_y[102:97], zero[103]
  input  logic [103:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // occupied[0], zero[7:1]
  output logic [7:0]   m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned ROWS = LAYERS * CELLS_Y;
  localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned XW   = (CELLS_X > 1) ? $clog2(CELLS_X) : 1;
  localparam int unsigned YW   = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
  localparam int unsigned NW   = 40;
  localparam int unsigned EW   = 44;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_LXY    = 4'd3;
  localparam logic [3:0] S_DLOAD  = 4'd4;
  localparam logic [3:0] S_DRUN   = 4'd5;
  localparam logic [3:0] S_DSTORE = 4'd6;
  localparam logic [3:0] S_EXI    = 4'd7;
  localparam logic [3:0] S_ROW    = 4'd8;
  localparam logic [3:0] S_CSQ    = 4'd9;
  localparam logic [3:0] S_CTST   = 4'd10;
  localparam logic [3:0] S_RWR    = 4'd11;
  localparam logic [3:0] S_RDA    = 4'd12;
  localparam logic [3:0] S_RDB    = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_q;

  // Configuration registers.
  logic [31:0] robot_x_q, robot_y_q, origin_x_q, origin_y_q;
  logic [15:0] cos_q, sin_q;
  logic [20:0] size_x_q, size_y_q;

  // Item registers.
  logic [31:0] pos_x_q, pos_y_q;
  logic [22:0] rad_q;
  logic [3:0]  layer_q;
  logic [5:0]  cell_x_q, cell_y_q;
  logic        rd_ok_q, from_item_q, res_q;

  // Datapath registers.
  logic signed [48:0] p_cx_q, p_sy_q, p_cy_q, p_sx_q;
  logic [35:0]   lx_q, ly_q;
  logic [47:0]   r4_q, eysq_q, sq_q;
  logic [1:0]    k_q;
  logic [NW-1:0] m_q;
  logic [20:0]   rem_q, dv_q;
  logic [5:0]    dcnt_q;
  logic          neg_q;
  logic [XW-1:0] x0_q, x1_q, i_q;
  logic [YW-1:0] y0_q, y1_q, j_q;
  logic [EW-1:0] ex0_q, ex_q, ey_q;
  logic          inr_q;
  logic [CELLS_X-1:0] mask_q;
  logic [AW-1:0] clr_q;

  logic         out_valid_q, out_bit_q;

  // Grid memory.
  logic [CELLS_X-1:0] mem_q [ROWS];
  logic [CELLS_X-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [CELLS_X-1:0] mem_wdata;

  logic        in_acc, out_free;
  logic [20:0] sx_eff, sy_eff;
  logic signed [32:0] dx, dy;
  logic [49:0] sum_x, sum_y;
  logic [NW-1:0] base40, off40, r40, num, mag;
  logic [20:0]   dsel;
  logic [21:0]   trial;
  logic          ge;
  logic [31:0]   lim, clamped;
  logic [21+XW:0] prodx;
  logic [21+YW:0] prody;
  logic [EW-1:0] abs_ex, abs_ey, two_r;
  logic [31:0]   row_sel, addr32, cx32;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_bit_q};

  assign sx_eff = (size_x_q == 21'd0) ? 21'd1 : size_x_q;
  assign sy_eff = (size_y_q == 21'd0) ? 21'd1 : size_y_q;
  assign dx = $signed({pos_x_q[31], pos_x_q}) - $signed({robot_x_q[31], robot_x_q});
  assign dy = $signed({pos_y_q[31], pos_y_q}) - $signed({robot_y_q[31], robot_y_q});
  assign sum_x = {p_cx_q[48], p_cx_q} + {p_sy_q[48], p_sy_q};
  assign sum_y = {p_cy_q[48], p_cy_q} - {p_sx_q[48], p_sx_q};

  // Bounding-box numerators: k bit 1 picks the axis, bit 0 the upper edge.
  always_comb begin
    base40 = k_q[1] ? {{4{ly_q[35]}}, ly_q} : {{4{lx_q[35]}}, lx_q};
    off40  = k_q[1] ? {{8{origin_y_q[31]}}, origin_y_q} : {{8{origin_x_q[31]}}, origin_x_q};
    r40    = {17'd0, rad_q};
    dsel   = k_q[1] ? sy_eff : sx_eff;
    num    = k_q[0] ? (base40 + r40 - off40) : (base40 - r40 - off40);
    // Floor division of a negative value divides the magnitude rounded up.
    mag    = num[NW-1] ? ((~num + 1'b1) + {19'd0, dsel} - 1'b1) : num;
  end

  assign trial = {rem_q, m_q[NW-1]};
  assign ge    = (trial >= {1'b0, dv_q});

  always_comb begin
    lim = k_q[1] ? 32'(CELLS_Y - 1) : 32'(CELLS_X - 1);
    if (neg_q) begin
      clamped = 32'd0;
    end else if (m_q > {8'd0, lim}) begin
      clamped = lim;
    end else begin
      clamped = m_q[31:0];
    end
  end

  assign prodx  = sx_eff * {x0_q, 1'b1};
  assign prody  = sy_eff * {y0_q, 1'b1};
  assign abs_ex = ex_q[EW-1] ? (~ex_q + 1'b1) : ex_q;
  assign abs_ey = ey_q[EW-1] ? (~ey_q + 1'b1) : ey_q;
  assign two_r  = {{(EW-24){1'b0}}, rad_q, 1'b0};

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = rdata_q | mask_q;
    row_sel   = 32'(j_q);
    if (state_q == S_RDA) begin
      row_sel = 32'(cell_y_q);
    end
    addr32   = 32'(layer_q) * 32'(CELLS_Y) + row_sel;
    mem_addr = addr32[AW-1:0];
    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      S_ROW:   mem_re = 1'b1;
      S_RDA:   mem_re = 1'b1;
      S_RWR:   mem_we = 1'b1;
      default: ;
    endcase
  end

  assign cx32 = 32'(cell_x_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q  <= '0;
      robot_y_q  <= '0;
      cos_q      <= 16'd16384;
      sin_q      <= '0;
      size_x_q   <= 21'd65536;
      size_y_q   <= 21'd65536;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegRobotX:    robot_x_q  <= cfg_data_i;
        RegRobotY:    robot_y_q  <= cfg_data_i;
        RegCosYaw:    cos_q      <= cfg_data_i[15:0];
        RegSinYaw:    sin_q      <= cfg_data_i[15:0];
        RegCellSizeX: size_x_q   <= cfg_data_i[20:0];
        RegCellSizeY: size_y_q   <= cfg_data_i[20:0];
        RegOriginX:   origin_x_q <= cfg_data_i;
        RegOriginY:   origin_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_bit_q   <= res_q;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, captured on the accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_x_q  <= s_axis_tdata_i[31:0];
      pos_y_q  <= s_axis_tdata_i[63:32];
      rad_q    <= s_axis_tdata_i[86:64];
      layer_q  <= s_axis_tdata_i[90:87];
      cell_x_q <= s_axis_tdata_i[96:91];
      cell_y_q <= s_axis_tdata_i[102:97];
      rd_ok_q  <= (32'(s_axis_tdata_i[90:87]) < LAYERS) &&
                  (32'(s_axis_tdata_i[96:91]) < CELLS_X) &&
                  (32'(s_axis_tdata_i[102:97]) < CELLS_Y);
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      from_item_q <= 1'b0;
      res_q       <= 1'b0;
      k_q         <= '0;
      dcnt_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      unique case (state_q)
        S_CLR: begin
          if (32'(clr_q) == ROWS - 1) begin
            clr_q   <= '0;
            state_q <= from_item_q ? S_DONE : S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_q       <= 1'b0;
            from_item_q <= 1'b1;
            unique case (s_axis_tuser_i)
              CmdClear: state_q <= S_CLR;
              CmdStamp: begin
                state_q <= (32'(s_axis_tdata_i[90:87]) < LAYERS) ? S_MUL : S_DONE;
              end
              CmdRead:  state_q <= S_RDA;
              default:  state_q <= S_DONE;
            endcase
          end
        end
        S_MUL: begin
          p_cx_q  <= $signed(cos_q) * dx;
          p_sy_q  <= $signed(sin_q) * dy;
          p_cy_q  <= $signed(cos_q) * dy;
          p_sx_q  <= $signed(sin_q) * dx;
          state_q <= S_LXY;
        end
        S_LXY: begin
          // The arithmetic shift by 14 is a floor division.
          lx_q    <= sum_x[49:14];
          ly_q    <= sum_y[49:14];
          r4_q    <= two_r[23:0] * two_r[23:0];
          k_q     <= '0;
          state_q <= S_DLOAD;
        end
        S_DLOAD: begin
          m_q     <= mag;
          neg_q   <= num[NW-1];
          dv_q    <= dsel;
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DRUN;
        end
        S_DRUN: begin
          m_q    <= {m_q[NW-2:0], ge};
          rem_q  <= ge ? 21'(trial - {1'b0, dv_q}) : trial[20:0];
          dcnt_q <= dcnt_q + 1'b1;
          if (32'(dcnt_q) == NW - 1) begin
            state_q <= S_DSTORE;
          end
        end
        S_DSTORE: begin
          unique case (k_q)
            2'd0: x0_q <= clamped[XW-1:0];
            2'd1: x1_q <= clamped[XW-1:0];
            2'd2: y0_q <= clamped[YW-1:0];
            2'd3: y1_q <= clamped[YW-1:0];
            default: ;
          endcase
          k_q     <= k_q + 1'b1;
          state_q <= (k_q == 2'd3) ? S_EXI : S_DLOAD;
        end
        S_EXI: begin
          // Twice the distance from the disc centre to the first cell centre.
          ex0_q   <= {{(EW-33){origin_x_q[31]}}, origin_x_q, 1'b0} + EW'(prodx) -
                     {{(EW-37){lx_q[35]}}, lx_q, 1'b0};
          ey_q    <= {{(EW-33){origin_y_q[31]}}, origin_y_q, 1'b0} + EW'(prody) -
                     {{(EW-37){ly_q[35]}}, ly_q, 1'b0};
          j_q     <= y0_q;
          state_q <= S_ROW;
        end
        S_ROW: begin
          ex_q   <= ex0_q;
          i_q    <= x0_q;
          mask_q <= '0;
          eysq_q <= abs_ey[23:0] * abs_ey[23:0];
          if (abs_ey <= two_r) begin
            state_q <= S_CSQ;
          end else if (j_q == y1_q) begin
            state_q <= S_DONE;
          end else begin
            j_q  <= j_q + 1'b1;
            ey_q <= ey_q + {{(EW-22){1'b0}}, sy_eff, 1'b0};
          end
        end
        S_CSQ: begin
          inr_q   <= (abs_ex <= two_r);
          sq_q    <= abs_ex[23:0] * abs_ex[23:0];
          state_q <= S_CTST;
        end
        S_CTST: begin
          if (inr_q && ({1'b0, sq_q} + {1'b0, eysq_q} <= {1'b0, r4_q})) begin
            mask_q[i_q] <= 1'b1;
          end
          if (i_q == x1_q) begin
            state_q <= S_RWR;
          end else begin
            i_q     <= i_q + 1'b1;
            ex_q    <= ex_q + {{(EW-22){1'b0}}, sx_eff, 1'b0};
            state_q <= S_CSQ;
          end
        end
        S_RWR: begin
          if (j_q == y1_q) begin
            state_q <= S_DONE;
          end else begin
            j_q     <= j_q + 1'b1;
            ey_q    <= ey_q + {{(EW-22){1'b0}}, sy_eff, 1'b0};
            state_q <= S_ROW;
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          res_q   <= rd_ok_q && rdata_q[cx32[XW-1:0]];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !s_axis_tready_o)
    else $error("beat accepted during clearing sweep");

  a_col_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CTST) |-> (i_q <= x1_q && i_q >= x0_q))
    else $error("column index left the bounding box");

  a_test_after_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CTST) |-> ($past(state_q) == S_CSQ))
    else $error("inside test without a fresh square");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && out_bit_q == $past(res_q)))
    else $error("result not moved to the output register");

endmodule
